FILE: sv/tbs_pkg.sv
package tbs_pkg;

  typedef struct packed {
    logic [31:0] vertex_a_x;
    logic [31:0] vertex_a_y;
    logic [31:0] vertex_a_z;
    logic [31:0] vertex_b_x;
    logic [31:0] vertex_b_y;
    logic [31:0] vertex_b_z;
    logic [31:0] vertex_c_x;
    logic [31:0] vertex_c_y;
    logic [31:0] vertex_c_z;
    logic        is_see_through;
    logic [31:0] tri_tag;
  } tbs_in_t;

  typedef struct packed {
    logic [1:0]  dominant_axis;
    logic [31:0] plane_nu;
    logic [31:0] plane_nv;
    logic [31:0] plane_nd;
    logic [31:0] beta_nu;
    logic [31:0] beta_nv;
    logic [31:0] beta_d;
    logic [31:0] gamma_nu;
    logic [31:0] gamma_nv;
    logic [31:0] gamma_d;
    logic        see_through_out;
    logic [31:0] tag_out;
  } tbs_out_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // operand class carried alongside a mul/div datapath
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } fp_spec_t;

  localparam axis_t AXIS_WRAP [5] = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_X, AXIS_Y};

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE    = 32'h3F80_0000;

  localparam int ADD_LAT = 4;
  localparam int MUL_LAT = 3;
  localparam int DIV_LAT = 29;

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // significand with hidden bit; subnormals carry a zero hidden bit
  function automatic logic [23:0] fp_mant(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  // effective biased exponent, subnormals sit at 1
  function automatic logic [7:0] fp_exp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
  endfunction

  function automatic logic [31:0] fp_neg(input logic [31:0] x);
    return {~x[31], x[30:0]};
  endfunction

  // |x| > |y|, false when either is NaN
  function automatic logic mag_gt(input logic [31:0] x, input logic [31:0] y);
    return !fp_is_nan(x) && !fp_is_nan(y) && (x[30:0] > y[30:0]);
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [31:0] pick3(input axis_t s, input logic [31:0] x0,
                                        input logic [31:0] x1, input logic [31:0] x2);
    logic [31:0] r;
    case (s)
      AXIS_X:  r = x0;
      AXIS_Y:  r = x1;
      AXIS_Z:  r = x2;
      default: r = x2;
    endcase
    return r;
  endfunction

  // sig[26] is the leading one, sig[2:0] guard/round/sticky; RNE with
  // gradual underflow and overflow to infinity
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [9:0] exp,
                                             input logic [26:0] sig);
    logic [26:0] s;
    logic [9:0]  sh;
    logic [9:0]  e;
    logic        inc;
    logic [24:0] m;
    logic [9:0]  ef;
    logic [22:0] frac;
    logic [31:0] r;
    if (exp < 10'sd1) begin
      sh = 10'(10'sd1 - exp);
      e  = 10'd0;
      if (sh > 10'd26) begin
        s = {26'd0, |sig};
      end else begin
        s = (sig >> sh[4:0]) | {26'd0, |(sig & ((27'd1 << sh[4:0]) - 27'd1))};
      end
    end else begin
      sh = 10'd0;
      s  = sig;
      e  = 10'(exp);
    end
    inc = s[2] & (s[3] | s[1] | s[0]);
    m   = {1'b0, s[26:3]} + {24'd0, inc};
    if (e == 10'd0) begin
      ef   = {9'd0, m[23]};
      frac = m[22:0];
    end else begin
      ef   = e + {9'd0, m[24]} + (sh & 10'd0);
      frac = m[24] ? m[23:1] : m[22:0];
    end
    if (ef >= 10'd255) r = {sign, 8'hFF, 23'd0};
    else               r = {sign, ef[7:0], frac};
    return r;
  endfunction

endpackage

FILE: sv/tbs_delay.sv
module tbs_delay #(
  parameter int W = 32,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < D; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign dout = pipe[D-1];

endmodule

FILE: sv/tbs_fadd.sv
module tbs_fadd import tbs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  typedef struct packed {
    logic nan;
    logic inf;
    logic inf_sign;
    logic both_zero;
    logic zero_sign;
  } add_spec_t;

  // align
  logic        swap;
  logic [31:0] big, lit;
  logic [7:0]  e_big, e_lit, dexp;
  logic [26:0] lit_ext, lit_al;
  add_spec_t   spec_c, spec1, spec2, spec3;
  logic        sign1, sub1;
  logic [7:0]  exp1;
  logic [26:0] mbig1, mlit1;
  // add
  logic [27:0] sum2;
  logic        sign2;
  logic [7:0]  exp2;
  // normalize
  logic [5:0]  lz;
  logic [27:0] norm;
  logic        sign3, zero3;
  logic signed [9:0] exp3;
  logic [26:0] sig3;

  always_comb begin
    swap    = b[30:0] > a[30:0];
    big     = swap ? b : a;
    lit     = swap ? a : b;
    e_big   = fp_exp(big);
    e_lit   = fp_exp(lit);
    dexp    = e_big - e_lit;
    lit_ext = {fp_mant(lit), 3'b000};
    if (dexp > 8'd26) begin
      lit_al = {26'd0, |lit_ext};
    end else begin
      lit_al = (lit_ext >> dexp[4:0])
             | {26'd0, |(lit_ext & ((27'd1 << dexp[4:0]) - 27'd1))};
    end
    spec_c.nan       = fp_is_nan(a) | fp_is_nan(b)
                     | (fp_is_inf(a) & fp_is_inf(b) & (a[31] ^ b[31]));
    spec_c.inf       = fp_is_inf(a) | fp_is_inf(b);
    spec_c.inf_sign  = fp_is_inf(a) ? a[31] : b[31];
    spec_c.both_zero = fp_is_zero(a) & fp_is_zero(b);
    spec_c.zero_sign = a[31] & b[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1 <= spec_c;
      sign1 <= big[31];
      sub1  <= big[31] ^ lit[31];
      exp1  <= e_big;
      mbig1 <= {fp_mant(big), 3'b000};
      mlit1 <= lit_al;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec2 <= spec1;
      sign2 <= sign1;
      exp2  <= exp1;
      sum2  <= sub1 ? ({1'b0, mbig1} - {1'b0, mlit1}) : ({1'b0, mbig1} + {1'b0, mlit1});
    end
  end

  always_comb begin
    lz   = lzc48({sum2, 20'd0});
    norm = sum2 << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec3 <= spec2;
      sign3 <= sign2;
      zero3 <= sum2 == 28'd0;
      exp3  <= $signed({2'b00, exp2}) + 10'sd1 - $signed({4'b0000, lz});
      sig3  <= {norm[27:2], |norm[1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (spec3.nan)            y <= CANON_NAN;
      else if (spec3.inf)       y <= {spec3.inf_sign, 8'hFF, 23'd0};
      else if (spec3.both_zero) y <= {spec3.zero_sign, 31'd0};
      else if (zero3)           y <= 32'd0;
      else                      y <= round_pack(sign3, exp3, sig3);
    end
  end

endmodule

FILE: sv/tbs_fmul.sv
module tbs_fmul import tbs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  fp_spec_t    spec1, spec2;
  logic [47:0] prod1;
  logic signed [9:0] exp1, exp2;
  logic [5:0]  lz;
  logic [47:0] norm;
  logic [26:0] sig2;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1      <= 48'(fp_mant(a)) * 48'(fp_mant(b));
      exp1       <= $signed({2'b00, fp_exp(a)}) + $signed({2'b00, fp_exp(b)}) - 10'sd126;
      spec1.nan  <= fp_is_nan(a) | fp_is_nan(b)
                  | (fp_is_inf(a) & fp_is_zero(b)) | (fp_is_inf(b) & fp_is_zero(a));
      spec1.inf  <= fp_is_inf(a) | fp_is_inf(b);
      spec1.zero <= fp_is_zero(a) | fp_is_zero(b);
      spec1.sign <= a[31] ^ b[31];
    end
  end

  always_comb begin
    lz   = lzc48(prod1);
    norm = prod1 << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec2 <= spec1;
      exp2  <= exp1 - $signed({4'b0000, lz});
      sig2  <= {norm[47:22], |norm[21:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (spec2.nan)       y <= CANON_NAN;
      else if (spec2.inf)  y <= {spec2.sign, 8'hFF, 23'd0};
      else if (spec2.zero) y <= {spec2.sign, 31'd0};
      else                 y <= round_pack(spec2.sign, exp2, sig2);
    end
  end

endmodule

FILE: sv/tbs_fdiv.sv
module tbs_fdiv import tbs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  localparam int NQ = 26;  // 24 significand bits plus guard and round

  logic [5:0]  lza, lzb;
  logic [23:0] xn1, yn1;
  logic signed [9:0] exp1;
  fp_spec_t    spec1;

  logic [24:0]       rem_q  [NQ+1];
  logic [NQ-1:0]     quo_q  [NQ+1];
  logic [23:0]       den_q  [NQ+1];
  logic signed [9:0] exp_q  [NQ+1];
  fp_spec_t          spec_q [NQ+1];

  always_comb begin
    lza = lzc48({fp_mant(a), 24'd0});
    lzb = lzc48({fp_mant(b), 24'd0});
  end

  // normalize subnormal operands
  always_ff @(posedge clk) begin
    if (en) begin
      xn1        <= fp_mant(a) << lza;
      yn1        <= fp_mant(b) << lzb;
      exp1       <= $signed({2'b00, fp_exp(a)}) - $signed({4'b0000, lza})
                  - $signed({2'b00, fp_exp(b)}) + $signed({4'b0000, lzb}) + 10'sd127;
      spec1.nan  <= fp_is_nan(a) | fp_is_nan(b)
                  | (fp_is_zero(a) & fp_is_zero(b)) | (fp_is_inf(a) & fp_is_inf(b));
      spec1.inf  <= fp_is_inf(a) | fp_is_zero(b);
      spec1.zero <= fp_is_zero(a) | fp_is_inf(b);
      spec1.sign <= a[31] ^ b[31];
    end
  end

  // pre-scale dividend so the quotient lands in [1,2)
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= (xn1 < yn1) ? {xn1, 1'b0} : {1'b0, xn1};
      exp_q[0]  <= (xn1 < yn1) ? exp1 - 10'sd1 : exp1;
      quo_q[0]  <= '0;
      den_q[0]  <= yn1;
      spec_q[0] <= spec1;
    end
  end

  // one restoring quotient bit per stage
  for (genvar i = 0; i < NQ; i++) begin : g_iter
    logic        ge;
    logic [24:0] diff;
    always_comb begin
      ge   = rem_q[i] >= {1'b0, den_q[i]};
      diff = ge ? (rem_q[i] - {1'b0, den_q[i]}) : rem_q[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1]  <= {diff[23:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][NQ-2:0], ge};
        den_q[i+1]  <= den_q[i];
        exp_q[i+1]  <= exp_q[i];
        spec_q[i+1] <= spec_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (spec_q[NQ].nan)       y <= CANON_NAN;
      else if (spec_q[NQ].inf)  y <= {spec_q[NQ].sign, 8'hFF, 23'd0};
      else if (spec_q[NQ].zero) y <= {spec_q[NQ].sign, 31'd0};
      else y <= round_pack(spec_q[NQ].sign, exp_q[NQ], {quo_q[NQ], rem_q[NQ] != 25'd0});
    end
  end

endmodule

FILE: sv/triangle_barycentric_setup.sv
// Throughput: one triangle per clock while setup is not stalled; most of the
// depth lies in the dividers, with their 26 restoring stages, behind the normal
// computation. A stall on setup while setup_valid is high freezes every stage;
// triangle_stall is the combinational inverse of the pipe enable.
// Reset (rst, synchronous, active high) clears only the stage valid bits.
module triangle_barycentric_setup import tbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     triangle_valid,
  output logic     triangle_stall,
  input  tbs_in_t  triangle,
  output logic     setup_valid,
  input  logic     setup_stall,
  output tbs_out_t setup
);

  // stage index at which each value is registered
  localparam int ST_EDGE = ADD_LAT;            // b = C-A, c = B-A
  localparam int ST_PROD = ST_EDGE + MUL_LAT;  // cross-product terms
  localparam int ST_NRM  = ST_PROD + ADD_LAT;  // N
  localparam int ST_SEL  = ST_NRM + 1;         // axis pick and operand select
  localparam int ST_PD   = ST_SEL + MUL_LAT;   // edge * vertex terms
  localparam int ST_DD   = ST_PD + ADD_LAT;    // edge plane offsets
  localparam int ST_DIV  = ST_SEL + DIV_LAT;   // N/N[k] and r = 1/N[k]
  localparam int ST_SCL  = ST_DIV + MUL_LAT;   // scaled terms
  localparam int ST_SUM  = ST_SCL + ADD_LAT;   // x + y partial of plane_nd
  localparam int ST_OUT  = ST_SUM + ADD_LAT;   // result word

  // ---------------------------------------------------------------------
  // Global advance: the whole pipe moves unless the result word is held.
  // ---------------------------------------------------------------------
  logic          en;
  logic [ST_OUT:0] vld;
  tbs_in_t       in_q;

  assign en             = !(vld[ST_OUT] && setup_stall);
  assign triangle_stall = !en;
  assign setup_valid    = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_OUT-1:0], triangle_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= triangle;
    end
  end

  logic [31:0] va [3];
  logic [31:0] vb [3];
  logic [31:0] vc [3];

  assign va[0] = in_q.vertex_a_x;
  assign va[1] = in_q.vertex_a_y;
  assign va[2] = in_q.vertex_a_z;
  assign vb[0] = in_q.vertex_b_x;
  assign vb[1] = in_q.vertex_b_y;
  assign vb[2] = in_q.vertex_b_z;
  assign vc[0] = in_q.vertex_c_x;
  assign vc[1] = in_q.vertex_c_y;
  assign vc[2] = in_q.vertex_c_z;

  // ---------------------------------------------------------------------
  // Edges and normal N = b x c, each product and difference rounded alone
  // ---------------------------------------------------------------------
  logic [31:0] eb [3];
  logic [31:0] ec [3];
  logic [31:0] ta [3];
  logic [31:0] tb [3];
  logic [31:0] nrm [3];

  for (genvar i = 0; i < 3; i++) begin : g_edge
    tbs_fadd u_eb (.clk, .en, .a(vc[i]), .b(fp_neg(va[i])), .y(eb[i]));
    tbs_fadd u_ec (.clk, .en, .a(vb[i]), .b(fp_neg(va[i])), .y(ec[i]));
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int L = (i + 2) % 3;
    tbs_fmul u_ta (.clk, .en, .a(eb[J]), .b(ec[L]), .y(ta[i]));
    tbs_fmul u_tb (.clk, .en, .a(eb[L]), .b(ec[J]), .y(tb[i]));
    tbs_fadd u_n  (.clk, .en, .a(ta[i]), .b(fp_neg(tb[i])), .y(nrm[i]));
  end

  // edges and vertex A brought up to the normal
  logic [191:0] edge_n;
  logic [95:0]  va_n;

  tbs_delay #(.W(192), .D(ST_NRM - ST_EDGE)) u_dly_edge (
    .clk, .en,
    .din ({eb[0], eb[1], eb[2], ec[0], ec[1], ec[2]}),
    .dout(edge_n)
  );

  tbs_delay #(.W(96), .D(ST_NRM)) u_dly_va (
    .clk, .en,
    .din ({va[0], va[1], va[2]}),
    .dout(va_n)
  );

  // ---------------------------------------------------------------------
  // Dominant axis: strict compares on |N|, so ties and NaN fall to the
  // later axis. The denominator b[u]c[v]-b[v]c[u] is exactly N[k].
  // ---------------------------------------------------------------------
  axis_t       k_c, u_c, v_c;
  logic [31:0] ebn [3];
  logic [31:0] ecn [3];
  logic [31:0] van [3];

  assign ebn[0] = edge_n[191:160];
  assign ebn[1] = edge_n[159:128];
  assign ebn[2] = edge_n[127:96];
  assign ecn[0] = edge_n[95:64];
  assign ecn[1] = edge_n[63:32];
  assign ecn[2] = edge_n[31:0];
  assign van[0] = va_n[95:64];
  assign van[1] = va_n[63:32];
  assign van[2] = va_n[31:0];

  always_comb begin
    if (mag_gt(nrm[0], nrm[1])) begin
      k_c = mag_gt(nrm[0], nrm[2]) ? AXIS_X : AXIS_Z;
    end else begin
      k_c = mag_gt(nrm[1], nrm[2]) ? AXIS_Y : AXIS_Z;
    end
    u_c = AXIS_WRAP[3'(k_c) + 3'd1];
    v_c = AXIS_WRAP[3'(k_c) + 3'd2];
  end

  axis_t       k_s;
  logic [31:0] nk_s, nu_s, nv_s, npk_s;
  logic [31:0] ebu_s, ebv_s, ecu_s, ecv_s, au_s, av_s;
  logic [31:0] nk_c;

  assign nk_c = pick3(k_c, nrm[0], nrm[1], nrm[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      k_s   <= k_c;
      nk_s  <= nk_c;
      nu_s  <= pick3(u_c, nrm[0], nrm[1], nrm[2]);
      nv_s  <= pick3(v_c, nrm[0], nrm[1], nrm[2]);
      ebu_s <= pick3(u_c, ebn[0], ebn[1], ebn[2]);
      ebv_s <= pick3(v_c, ebn[0], ebn[1], ebn[2]);
      ecu_s <= pick3(u_c, ecn[0], ecn[1], ecn[2]);
      ecv_s <= pick3(v_c, ecn[0], ecn[1], ecn[2]);
      au_s  <= pick3(u_c, van[0], van[1], van[2]);
      av_s  <= pick3(v_c, van[0], van[1], van[2]);
      // N[k]/N[k]: one for finite nonzero, NaN otherwise
      npk_s <= (fp_is_nan(nk_c) || fp_is_inf(nk_c) || fp_is_zero(nk_c)) ? CANON_NAN : FP_ONE;
    end
  end

  // ---------------------------------------------------------------------
  // Divides (long path) and edge plane offsets (short path, then delayed)
  // ---------------------------------------------------------------------
  logic [31:0] npu_d, npv_d, rcp_d;

  tbs_fdiv u_div_u (.clk, .en, .a(nu_s),   .b(nk_s), .y(npu_d));
  tbs_fdiv u_div_v (.clk, .en, .a(nv_s),   .b(nk_s), .y(npv_d));
  tbs_fdiv u_div_r (.clk, .en, .a(FP_ONE), .b(nk_s), .y(rcp_d));

  logic [31:0] p1, p2, p3, p4, ddb, ddg;

  tbs_fmul u_p1 (.clk, .en, .a(ebv_s), .b(au_s), .y(p1));
  tbs_fmul u_p2 (.clk, .en, .a(ebu_s), .b(av_s), .y(p2));
  tbs_fmul u_p3 (.clk, .en, .a(ecu_s), .b(av_s), .y(p3));
  tbs_fmul u_p4 (.clk, .en, .a(ecv_s), .b(au_s), .y(p4));
  tbs_fadd u_ddb (.clk, .en, .a(p1), .b(fp_neg(p2)), .y(ddb));
  tbs_fadd u_ddg (.clk, .en, .a(p3), .b(fp_neg(p4)), .y(ddg));

  logic [63:0]  dd_d;
  logic [161:0] sel_d;
  logic [95:0]  va_d;

  tbs_delay #(.W(64), .D(ST_DIV - ST_DD)) u_dly_dd (
    .clk, .en, .din({ddb, ddg}), .dout(dd_d)
  );

  tbs_delay #(.W(162), .D(ST_DIV - ST_SEL)) u_dly_sel (
    .clk, .en,
    .din ({2'(k_s), npk_s, ebu_s, ebv_s, ecu_s, ecv_s}),
    .dout(sel_d)
  );

  tbs_delay #(.W(96), .D(ST_DIV - ST_NRM)) u_dly_va2 (
    .clk, .en, .din(va_n), .dout(va_d)
  );

  axis_t       k_d;
  logic [31:0] npk_d, ebu_d, ebv_d, ecu_d, ecv_d;
  logic [31:0] np [3];

  assign k_d   = axis_t'(sel_d[161:160]);
  assign npk_d = sel_d[159:128];
  assign ebu_d = sel_d[127:96];
  assign ebv_d = sel_d[95:64];
  assign ecu_d = sel_d[63:32];
  assign ecv_d = sel_d[31:0];

  // put N/N[k] back in x, y, z order
  always_comb begin
    case (k_d)
      AXIS_X: begin
        np[0] = npk_d; np[1] = npu_d; np[2] = npv_d;
      end
      AXIS_Y: begin
        np[0] = npv_d; np[1] = npk_d; np[2] = npu_d;
      end
      AXIS_Z: begin
        np[0] = npu_d; np[1] = npv_d; np[2] = npk_d;
      end
      default: begin
        np[0] = npu_d; np[1] = npv_d; np[2] = npk_d;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Scale by r, and plane_nd summed x then y then z
  // ---------------------------------------------------------------------
  logic [31:0] m0, m1, m2, m2_d, s01, nd;
  logic [31:0] bnu, bnv, bd, gnu, gnv, gd;

  tbs_fmul u_m0 (.clk, .en, .a(np[0]), .b(va_d[95:64]), .y(m0));
  tbs_fmul u_m1 (.clk, .en, .a(np[1]), .b(va_d[63:32]), .y(m1));
  tbs_fmul u_m2 (.clk, .en, .a(np[2]), .b(va_d[31:0]),  .y(m2));

  tbs_fmul u_bnu (.clk, .en, .a(rcp_d), .b(fp_neg(ebv_d)), .y(bnu));
  tbs_fmul u_bnv (.clk, .en, .a(rcp_d), .b(ebu_d),         .y(bnv));
  tbs_fmul u_bd  (.clk, .en, .a(rcp_d), .b(dd_d[63:32]),   .y(bd));
  tbs_fmul u_gnu (.clk, .en, .a(rcp_d), .b(ecv_d),         .y(gnu));
  tbs_fmul u_gnv (.clk, .en, .a(rcp_d), .b(fp_neg(ecu_d)), .y(gnv));
  tbs_fmul u_gd  (.clk, .en, .a(rcp_d), .b(dd_d[31:0]),    .y(gd));

  tbs_fadd u_s01 (.clk, .en, .a(m0), .b(m1), .y(s01));

  tbs_delay #(.W(32), .D(ST_SUM - ST_SCL)) u_dly_m2 (
    .clk, .en, .din(m2), .dout(m2_d)
  );

  tbs_fadd u_nd (.clk, .en, .a(s01), .b(m2_d), .y(nd));

  // ---------------------------------------------------------------------
  // Align the rest with plane_nd
  // ---------------------------------------------------------------------
  logic [191:0] bg_o;
  logic [65:0]  pl_o;
  logic [32:0]  pass_o;

  tbs_delay #(.W(192), .D(ST_OUT - ST_SCL)) u_dly_bg (
    .clk, .en, .din({bnu, bnv, bd, gnu, gnv, gd}), .dout(bg_o)
  );

  tbs_delay #(.W(66), .D(ST_OUT - ST_DIV)) u_dly_pl (
    .clk, .en, .din({2'(k_d), npu_d, npv_d}), .dout(pl_o)
  );

  tbs_delay #(.W(33), .D(ST_OUT)) u_dly_pass (
    .clk, .en, .din({in_q.is_see_through, in_q.tri_tag}), .dout(pass_o)
  );

  assign setup.dominant_axis   = pl_o[65:64];
  assign setup.plane_nu        = pl_o[63:32];
  assign setup.plane_nv        = pl_o[31:0];
  assign setup.plane_nd        = nd;
  assign setup.beta_nu         = bg_o[191:160];
  assign setup.beta_nv         = bg_o[159:128];
  assign setup.beta_d          = bg_o[127:96];
  assign setup.gamma_nu        = bg_o[95:64];
  assign setup.gamma_nv        = bg_o[63:32];
  assign setup.gamma_d         = bg_o[31:0];
  assign setup.see_through_out = pass_o[32];
  assign setup.tag_out         = pass_o[31:0];

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // with no NaN in N, the picked axis is never smaller than the other two
  a_axis_max: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_SEL] && !fp_is_nan(nu_s) && !fp_is_nan(nv_s) && !fp_is_nan(nk_s))
      |-> (!mag_gt(nu_s, nk_s) && !mag_gt(nv_s, nk_s)))
    else $error("dominant axis not the largest |N|");

  // a held result freezes every valid bit
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  // an entering word always advances when the pipe moves
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && en) |=> vld[1])
    else $error("word lost between stage 0 and 1");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tbs_pkg::*;

  localparam int N_RANDOM    = 440;
  localparam int CALM_TAIL   = 60;      // last words sent with no idling
  localparam int DRAIN_WAIT  = 100;     // settling wait after the last expected word
  localparam int CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst;
  logic     triangle_valid;
  logic     triangle_stall;
  tbs_in_t  triangle;
  logic     setup_valid;
  logic     setup_stall;
  tbs_out_t setup;

  triangle_barycentric_setup u_top (
    .clk            (clk),
    .rst            (rst),
    .triangle_valid (triangle_valid),
    .triangle_stall (triangle_stall),
    .triangle       (triangle),
    .setup_valid    (setup_valid),
    .setup_stall    (setup_stall),
    .setup          (setup)
  );

  tbs_in_t  tri_pending[$];   // triangles not yet offered
  tbs_out_t setup_due[$];     // predicted setup words, oldest first
  int       n_total;
  int       n_sent;
  int       n_seen;
  int       n_errors;
  int       cycles;
  bit       calm;             // no idling on either side
  bit       done;

  // ---------------------------------------------------------------------
  // Single-precision arithmetic, RNE, gradual underflow, canonical NaN.
  // ---------------------------------------------------------------------
  function automatic logic [31:0] fp_round(bit s, int e, logic [127:0] m);
    int          p, ee, sh;
    logic [127:0] q, rem, half;
    longint      t;
    if (m == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    ee = p + e + 127;          // biased exponent of the leading one
    if (ee < 1) ee = 1;        // subnormal range keeps a fixed lsb weight
    sh = (ee - 150) - e;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh >= 128) begin
      q = '0;
    end else begin
      q    = m >> sh;
      rem  = m & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 128'd1;
    end
    // a rounding carry walks into the exponent field on its own
    t = (longint'(ee - 1) << 23) + longint'(q[31:0]);
    if (t >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
    return {s, t[30:0]};
  endfunction

  function automatic void fp_split(input logic [31:0] x, output logic [127:0] m,
                                   output int e);
    if (x[30:23] == 8'd0) begin
      m = {105'd0, x[22:0]};
      e = -149;
    end else begin
      m = {104'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic bit f_nan(logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic bit f_inf(logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic bit f_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    logic [127:0] ma, mb, ml, ms;
    int           ea, eb, el, es, d, e;
    bit           sl, ss;
    if (f_nan(a) || f_nan(b)) return CANON_NAN;
    if (f_inf(a) && f_inf(b)) return (a[31] == b[31]) ? a : CANON_NAN;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    if (ea >= eb) begin
      ml = ma; el = ea; sl = a[31]; ms = mb; es = eb; ss = b[31];
    end else begin
      ml = mb; el = eb; sl = b[31]; ms = ma; es = ea; ss = a[31];
    end
    d = el - es;
    if (d > 50) begin
      // far smaller operand only decides the sticky side
      ml = ml << 50;
      ms = (ms != 0) ? 128'd1 : 128'd0;
      e  = el - 50;
    end else begin
      ml = ml << d;
      e  = es;
    end
    if (sl == ss) return fp_round(sl, e, ml + ms);
    if (ml > ms)  return fp_round(sl, e, ml - ms);
    if (ms > ml)  return fp_round(ss, e, ms - ml);
    return 32'd0;               // exact cancellation is +0 under RNE
  endfunction

  function automatic logic [31:0] f_neg(logic [31:0] a);
    return {~a[31], a[30:0]};
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    return f_add(a, f_neg(b));
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic [127:0] ma, mb;
    int           ea, eb;
    bit           s;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return CANON_NAN;
    if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) return CANON_NAN;
    if (f_inf(a) || f_inf(b)) return {s, 8'hFF, 23'd0};
    if (f_zero(a) || f_zero(b)) return {s, 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_round(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    logic [127:0] ma, mb, q, rem;
    int           ea, eb;
    bit           s;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return CANON_NAN;
    if ((f_inf(a) && f_inf(b)) || (f_zero(a) && f_zero(b))) return CANON_NAN;
    if (f_inf(a) || f_zero(b)) return {s, 8'hFF, 23'd0};
    if (f_zero(a) || f_inf(b)) return {s, 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    q   = (ma << 80) / mb;
    rem = (ma << 80) % mb;
    return fp_round(s, ea - eb - 81, {q[126:0], rem != 0});
  endfunction

  // strict |x| > |y|; any NaN makes it false
  function automatic bit f_mag_gt(logic [31:0] x, logic [31:0] y);
    return !f_nan(x) && !f_nan(y) && (x[30:0] > y[30:0]);
  endfunction

  // ---------------------------------------------------------------------
  // Setup prediction for one triangle
  // ---------------------------------------------------------------------
  function automatic tbs_out_t predict_setup(tbs_in_t t);
    tbs_out_t    o;
    logic [31:0] a [3];
    logic [31:0] pb [3];
    logic [31:0] pc [3];
    logic [31:0] eb [3];
    logic [31:0] ec [3];
    logic [31:0] nrm [3];
    logic [31:0] np [3];
    logic [31:0] nd, den, r;
    int          k, u, v;
    a  = '{t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
    pb = '{t.vertex_b_x, t.vertex_b_y, t.vertex_b_z};
    pc = '{t.vertex_c_x, t.vertex_c_y, t.vertex_c_z};
    for (int i = 0; i < 3; i++) begin
      eb[i] = f_sub(pc[i], a[i]);   // b = C - A
      ec[i] = f_sub(pb[i], a[i]);   // c = B - A
    end
    nrm[0] = f_sub(f_mul(eb[1], ec[2]), f_mul(eb[2], ec[1]));
    nrm[1] = f_sub(f_mul(eb[2], ec[0]), f_mul(eb[0], ec[2]));
    nrm[2] = f_sub(f_mul(eb[0], ec[1]), f_mul(eb[1], ec[0]));
    // ties go to the later axis
    if (f_mag_gt(nrm[0], nrm[1])) k = f_mag_gt(nrm[0], nrm[2]) ? 0 : 2;
    else                          k = f_mag_gt(nrm[1], nrm[2]) ? 1 : 2;
    u = (k + 1) % 3;
    v = (k + 2) % 3;
    for (int i = 0; i < 3; i++) np[i] = f_div(nrm[i], nrm[k]);
    nd = f_add(f_mul(np[0], a[0]), f_mul(np[1], a[1]));
    nd = f_add(nd, f_mul(np[2], a[2]));
    den = f_sub(f_mul(eb[u], ec[v]), f_mul(eb[v], ec[u]));
    r   = f_div(FP_ONE, den);
    o.dominant_axis   = axis_t'(k);
    o.plane_nu        = np[u];
    o.plane_nv        = np[v];
    o.plane_nd        = nd;
    o.beta_nu         = f_mul(r, f_neg(eb[v]));
    o.beta_nv         = f_mul(r, eb[u]);
    o.beta_d          = f_mul(r, f_sub(f_mul(eb[v], a[u]), f_mul(eb[u], a[v])));
    o.gamma_nu        = f_mul(r, ec[v]);
    o.gamma_nv        = f_mul(r, f_neg(ec[u]));
    o.gamma_d         = f_mul(r, f_sub(f_mul(ec[u], a[v]), f_mul(ec[v], a[u])));
    o.see_through_out = t.is_see_through;
    o.tag_out         = t.tri_tag;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_tri(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                         logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                         logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                         logic flag, logic [31:0] tag);
    tbs_in_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz, flag, tag};
    tri_pending.push_back(t);
  endtask

  // coordinate style is chosen per triangle so degenerate shapes show up
  function automatic logic [31:0] rand_coord(int style);
    logic [31:0] x;
    case (style)
      0: x = {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
      1: begin
        // tiny integer grid: ties, zero area, exact cancellation
        case ($urandom_range(0, 4))
          0: x = 32'h0000_0000;
          1: x = 32'h3F80_0000;
          2: x = 32'hBF80_0000;
          3: x = 32'h4000_0000;
          default: x = 32'h8000_0000;
        endcase
      end
      2: x = {1'($urandom), 8'($urandom_range(0, 20)), 23'($urandom)};
      default: x = $urandom;
    endcase
    return x;
  endfunction

  task automatic add_random_tri();
    int          style, pick;
    logic [31:0] v [9];
    pick = $urandom_range(0, 99);
    style = (pick < 70) ? 0 : (pick < 85) ? 1 : (pick < 90) ? 2 : 3;
    for (int i = 0; i < 9; i++) v[i] = rand_coord(style);
    // occasionally collapse two vertices
    if ($urandom_range(0, 19) == 0) begin
      v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
    end
    add_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
            1'($urandom), $urandom);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 60)
      $display("word %0d: %s got %08h want %08h", n_seen, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset and stimulus
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst      = 1'b1;
    n_errors = 0;
    n_sent   = 0;
    n_seen   = 0;
    done     = 1'b0;

    // flat triangles in each axis plane
    add_tri(0, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 0, 1'b0, 32'd0);
    add_tri(0, 0, 0, 32'h3F80_0000, 0, 0, 0, 0, 32'h3F80_0000, 1'b1, 32'd1);
    add_tri(0, 0, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 1'b0, 32'd2);
    // equal |N| on all axes: later axis wins
    add_tri(0, 0, 0, 32'h3F80_0000, 32'h3F80_0000, 0, 0, 32'h3F80_0000,
            32'h3F80_0000, 1'b1, 32'hFFFF_FFFF);
    // tie between x and y only
    add_tri(0, 0, 0, 0, 0, 32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 0,
            1'b0, 32'h8000_0000);
    // zero-area: all vertices coincide (0/0 everywhere)
    add_tri(32'h4040_0000, 32'h4040_0000, 32'h4040_0000, 32'h4040_0000,
            32'h4040_0000, 32'h4040_0000, 32'h4040_0000, 32'h4040_0000,
            32'h4040_0000, 1'b1, 32'd5);
    // collinear vertices
    add_tri(0, 0, 0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
            32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 1'b0, 32'd6);
    // NaN vertex coordinate
    add_tri(32'h7FC0_0001, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 0,
            1'b0, 32'd7);
    add_tri(0, 32'hFFFF_FFFF, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 0,
            1'b1, 32'd8);
    // infinities
    add_tri(0, 0, 0, 32'h7F80_0000, 0, 0, 0, 32'h3F80_0000, 0, 1'b0, 32'd9);
    add_tri(32'hFF80_0000, 0, 0, 32'h3F80_0000, 32'h3F80_0000, 0,
            0, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'd10);
    // largest finite values: overflow in the products
    add_tri(32'hFF7F_FFFF, 32'h7F7F_FFFF, 0, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
            32'h7F7F_FFFF, 0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0, 32'd11);
    // subnormals: underflow to zero in the products
    add_tri(32'h0000_0001, 0, 32'h8000_0001, 32'h007F_FFFF, 32'h0000_0001, 0,
            0, 32'h807F_FFFF, 32'h0000_0001, 1'b1, 32'd12);
    // signed zeros mixed in
    add_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hBF80_0000,
            32'h8000_0000, 0, 32'h8000_0000, 32'h4000_0000, 32'h8000_0000,
            1'b1, 32'hFFFF_FFFF);
    // generic triangle with offset vertex A
    add_tri(32'h4120_0000, 32'hC0A0_0000, 32'h3E80_0000, 32'h4130_0000,
            32'hC080_0000, 32'h3F00_0000, 32'h4128_0000, 32'hC0C0_0000,
            32'h4000_0000, 1'b0, 32'h1234_5678);
    // raw bit patterns
    add_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_tri(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h5555_5555, 1'b0, 32'hAAAA_5555);

    for (int i = 0; i < N_RANDOM; i++) add_random_tri();
    n_total = tri_pending.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (tri_pending.size() == 0 && !triangle_valid);
    wait (setup_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    done = 1'b1;
    if (n_errors == 0 && setup_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: offers queued triangles with random idle bursts.
  // ---------------------------------------------------------------------
  int tri_idle;

  always @(posedge clk) begin
    tbs_in_t nxt_word;
    logic    nxt_valid;
    bit      free;
    if (rst) begin
      triangle_valid <= 1'b0;
      triangle       <= '0;
      tri_idle       = 0;
    end else begin
      nxt_word  = triangle;
      nxt_valid = triangle_valid;
      free      = !triangle_valid || !triangle_stall;
      if (triangle_valid && !triangle_stall) begin
        setup_due.push_back(predict_setup(triangle));
        n_sent++;
      end
      if (free) begin
        if (tri_idle > 0) begin
          tri_idle--;
          nxt_valid = 1'b0;
        end else if (tri_pending.size() > 0) begin
          nxt_word  = tri_pending.pop_front();
          nxt_valid = 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) tri_idle = $urandom_range(1, 4);
        end else begin
          nxt_valid = 1'b0;
        end
      end
      triangle_valid <= nxt_valid;
      triangle       <= nxt_word;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random stall bursts on the setup side, in-order compare.
  // ---------------------------------------------------------------------
  int setup_hold;

  always @(posedge clk) begin
    tbs_out_t want;
    if (rst) begin
      setup_stall <= 1'b0;
      setup_hold  = 0;
    end else begin
      if (setup_valid && !setup_stall) begin
        if (setup_due.size() == 0) begin
          report("unexpected word", setup.tag_out, 32'd0);
        end else begin
          want = setup_due.pop_front();
          check_field("dominant_axis", 32'(setup.dominant_axis),
                      32'(want.dominant_axis));
          check_field("plane_nu", setup.plane_nu, want.plane_nu);
          check_field("plane_nv", setup.plane_nv, want.plane_nv);
          check_field("plane_nd", setup.plane_nd, want.plane_nd);
          check_field("beta_nu", setup.beta_nu, want.beta_nu);
          check_field("beta_nv", setup.beta_nv, want.beta_nv);
          check_field("beta_d", setup.beta_d, want.beta_d);
          check_field("gamma_nu", setup.gamma_nu, want.gamma_nu);
          check_field("gamma_nv", setup.gamma_nv, want.gamma_nv);
          check_field("gamma_d", setup.gamma_d, want.gamma_d);
          check_field("see_through_out", 32'(setup.see_through_out),
                      32'(want.see_through_out));
          check_field("tag_out", setup.tag_out, want.tag_out);
        end
        n_seen++;
      end
      if (setup_hold > 0) begin
        setup_hold--;
        setup_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        setup_hold = $urandom_range(0, 3);
        setup_stall <= 1'b1;
      end else begin
        setup_stall <= 1'b0;
      end
    end
  end

  // calm tail, cycle limit
  always @(posedge clk) begin
    if (rst) begin
      cycles = 0;
      calm   = 1'b0;
    end else begin
      cycles++;
      if (n_total - n_sent <= CALM_TAIL) calm = 1'b1;
      if (cycles >= CYCLE_LIMIT && !done) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
